// ===== rtl/psd_pkg.sv =====
// Package for the population standard deviation unit.
// Field widths, default depth and sequencer state codes. No dependencies.
package psd_pkg;
	localparam int SAMPLE_W    = 16;
	localparam int COUNT_W     = 11;
	localparam int DEF_MAX_SAMPLES = 1024;

	// sequencer state codes
	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_MDIV = 3'd1;
	localparam logic [2:0] ST_SUMQ = 3'd2;
	localparam logic [2:0] ST_VDIV = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
endpackage

// ===== rtl/population_std_deviation_unit.sv =====
// Population standard deviation unit, top level and only module.
// Depends on psd_pkg. Sample buffer, bit-serial divider, serial-parallel
// squarer and bit-pair square root, all sharing one narrow datapath.
// Loading: one sample per cycle, back to back, until the sample marked last.
// After the last request: mean divide, sum pass (one 16-step shift-add
// multiply per sample plus read and accumulate), variance divide, bit-pair
// root, then valid is raised. The next set is taken only after the result
// is accepted. No clearing pass; reset clears control state.
module population_std_deviation_unit
	#(parameter int MAX_SAMPLES = psd_pkg::DEF_MAX_SAMPLES)
	(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] std_dev, [31:16] mean_value,
	                               // [42:32] sample_count, [47:43] zero
	output logic        m_tuser    // overflow
	);
	import psd_pkg::*;

	localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int NW   = $clog2(MAX_SAMPLES + 1);
	localparam int TW   = SAMPLE_W + NW;
	localparam int SQ_W = 2 * SAMPLE_W + NW;
	localparam int DW   = (TW > SQ_W) ? TW : SQ_W;
	localparam int MW   = 2 * SAMPLE_W;
	localparam int CW   = $clog2(DW + 1);

	// storage and accumulation
	logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
	logic [SAMPLE_W-1:0] rd_s1;
	logic [NW-1:0]       cnt_q;
	logic [TW-1:0]       total_q;
	logic                drop_q;
	logic [2:0]          state_q;

	// shared divider / root / multiplier registers
	logic [DW-1:0]       num_q;
	logic [NW:0]         rem_q;
	logic [CW-1:0]       step_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [NW-1:0]       idx_q;
	logic [SAMPLE_W-1:0] mpl_q;
	logic [MW-1:0]       prod_q;
	logic [SQ_W-1:0]     acc_q;
	logic                mphase_q;
	logic [SQ_W-1:0]     rv_q;
	logic [SAMPLE_W+1:0] rr_q;
	logic [SAMPLE_W-1:0] root_q;
	logic [SAMPLE_W-1:0] sd_q;

	logic stored, take;
	logic [NW:0] rem_sh;
	logic [SAMPLE_W-1:0] dev;
	logic [SAMPLE_W+1:0] rtry, rsh;

	assign s_tready = (state_q == ST_LOAD);
	assign take     = s_tvalid && s_tready;
	assign stored   = cnt_q < NW'(MAX_SAMPLES);

	// buffer write and registered read
	always_ff @(posedge clk) begin
		if (take && stored)
			mem[cnt_q[AW-1:0]] <= s_tdata;
		rd_s1 <= mem[idx_q[AW-1:0]];
	end

	// restoring divider step: remainder shift in one numerator bit
	assign rem_sh = {rem_q[NW-1:0], num_q[DW-1]};
	// absolute deviation of the buffered sample
	assign dev = (rd_s1 >= mean_q) ? rd_s1 - mean_q : mean_q - rd_s1;
	// root step: two radicand bits per cycle
	assign rsh  = {rr_q[SAMPLE_W-1:0], rv_q[SQ_W-1 -: 2]};
	assign rtry = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			total_q  <= '0;
			drop_q   <= 1'b0;
			m_tvalid <= 1'b0;
			step_q   <= '0;
			idx_q    <= '0;
			mphase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (stored) begin
							cnt_q   <= cnt_q + 1'b1;
							total_q <= total_q + TW'(s_tdata);
						end else
							drop_q <= 1'b1;
						if (s_tlast) begin
							num_q   <= DW'(stored ? total_q + TW'(s_tdata) : total_q)
							           << (DW - TW);
							rem_q   <= '0;
							step_q  <= CW'(TW);
							state_q <= ST_MDIV;
						end
					end
				end
				// mean = total / n, one quotient bit per cycle
				ST_MDIV: begin
					if (step_q != '0) begin
						step_q <= step_q - 1'b1;
						if (rem_sh >= {1'b0, cnt_q}) begin
							rem_q <= rem_sh - {1'b0, cnt_q};
							num_q <= {num_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							num_q <= {num_q[DW-2:0], 1'b0};
						end
					end else begin
						mean_q   <= num_q[SAMPLE_W-1:0];
						idx_q    <= '0;
						acc_q    <= '0;
						mphase_q <= 1'b0;
						step_q   <= '0;
						state_q  <= (cnt_q == '0) ? ST_OUT : ST_SUMQ;
						sd_q     <= '0;
					end
				end
				// sum of squared deviations, shift-add multiply per sample
				ST_SUMQ: begin
					if (!mphase_q) begin
						// read data for idx_q lands in rd_s1 on the next cycle
						if (step_q == CW'(1)) begin
							mpl_q    <= dev;
							prod_q   <= '0;
							mphase_q <= 1'b1;
							step_q   <= CW'(SAMPLE_W);
						end else
							step_q <= CW'(1);
					end else if (step_q != '0) begin
						step_q <= step_q - 1'b1;
						prod_q <= (prod_q << 1) +
						          (mpl_q[SAMPLE_W-1] ? MW'(dev) : MW'(0));
						mpl_q  <= mpl_q << 1;
					end else begin
						acc_q    <= acc_q + SQ_W'(prod_q);
						mphase_q <= 1'b0;
						if (idx_q == cnt_q - 1'b1) begin
							num_q   <= DW'(acc_q + SQ_W'(prod_q)) << (DW - SQ_W);
							rem_q   <= '0;
							step_q  <= CW'(SQ_W);
							state_q <= ST_VDIV;
						end else
							idx_q <= idx_q + 1'b1;
					end
				end
				// variance = sum / n
				ST_VDIV: begin
					if (step_q != '0) begin
						step_q <= step_q - 1'b1;
						if (rem_sh >= {1'b0, cnt_q}) begin
							rem_q <= rem_sh - {1'b0, cnt_q};
							num_q <= {num_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							num_q <= {num_q[DW-2:0], 1'b0};
						end
					end else begin
						// variance < 2^32, root needs its low 32 bits
						rv_q    <= SQ_W'(num_q[SQ_W-1:0]) << (SQ_W - MW);
						rr_q    <= '0;
						root_q  <= '0;
						step_q  <= CW'(SAMPLE_W);
						state_q <= ST_ROOT;
					end
				end
				// bit-pair square root
				ST_ROOT: begin
					if (step_q != '0) begin
						step_q <= step_q - 1'b1;
						rv_q   <= rv_q << 2;
						if (rsh >= rtry) begin
							rr_q   <= rsh - rtry;
							root_q <= {root_q[SAMPLE_W-2:0], 1'b1};
						end else begin
							rr_q   <= rsh;
							root_q <= {root_q[SAMPLE_W-2:0], 1'b0};
						end
					end else begin
						sd_q    <= root_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid)
						m_tvalid <= 1'b1;
					else if (m_tready) begin
						m_tvalid <= 1'b0;
						cnt_q    <= '0;
						total_q  <= '0;
						drop_q   <= 1'b0;
						state_q  <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign m_tdata = {5'b0, COUNT_W'(cnt_q), mean_q, sd_q};
	assign m_tuser = drop_q;

	// result only shown from the output state
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> state_q == ST_OUT)
		else $error("result valid outside output state");
	// no new request taken while a result is pending
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while result pending");
	// stored count never passes the buffer depth
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(MAX_SAMPLES))
		else $error("sample count beyond depth");
endmodule
